// ===== src/pcbf_pkg.sv =====
package pcbf_pkg;

    // Block geometry.
    localparam int BLOCK_BYTES = 64;
    localparam int IDX_W       = 6;
    localparam logic [IDX_W-1:0] LAST_INDEX = 6'd63;

    // Field widths.
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 256;
    localparam int ROFF_W   = 5;
    localparam int IN_DATA_W  = 280;
    localparam int OUT_DATA_W = 24;

    // Request kinds.
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Frame bytes.
    localparam logic [7:0] BYTE_PROBE_0 = 8'h01;
    localparam logic [7:0] BYTE_PROBE_1 = 8'h03;
    localparam logic [7:0] BYTE_PROBE_2 = 8'h00;
    localparam logic [7:0] BYTE_FILL    = 8'hFF;
    localparam logic [7:0] BYTE_RD_0    = 8'h03;
    localparam logic [7:0] BYTE_RD_1    = 8'h21;
    localparam logic [7:0] BYTE_RD_2    = 8'h02;
    localparam logic [7:0] BYTE_WR_0    = 8'h23;
    localparam logic [7:0] BYTE_WR_1    = 8'h01;
    localparam logic [7:0] BYTE_WR_2    = 8'h03;
    localparam logic [7:0] BYTE_END     = 8'hFE;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] BYTE_TAIL    = 8'h01;

    // Address word keeps bits 15..5; the CRC takes the low five bits.
    localparam logic [ADDR_W-1:0] ADDR_KEEP_MASK = 16'hFFE0;

    // Remainder of x^k modulo x^5 + x^4 + x^2 + 1, for k = 5..15.
    localparam logic [4:0] CRC_TERM [0:10] = '{
        5'h15, 5'h1F, 5'h0B, 5'h16, 5'h19, 5'h07,
        5'h0E, 5'h1C, 5'h0D, 5'h1A, 5'h01
    };

    // One queued request, already classified.
    typedef struct packed {
        logic              is_write;
        logic [1:0]        port;
        logic [ADDR_W-1:0] addr_word;
        logic [ROFF_W-1:0] reply_offset;
        logic [DATA_W-1:0] data;
    } pcbf_desc_t;

    // Handshake between two parts: valid and ready.
    typedef struct packed {
        logic valid;
        logic ready;
    } pcbf_hs_t;

    // The CRC is linear, so each message bit adds its own remainder term.
    function automatic logic [4:0] addr_crc5(input logic [ADDR_W-1:0] a);
        logic [4:0] c;
        c = 5'd0;
        for (int b = 0; b < 11; b++)
        begin
            if (a[b + 5])
            begin
                c = c ^ CRC_TERM[b];
            end
        end
        return c;
    endfunction

endpackage

// ===== src/pcbf_front.sv =====
module pcbf_front (
    input  logic                             in_valid,
    input  logic                             in_type,
    input  logic [pcbf_pkg::IN_DATA_W-1:0]   in_data,
    output pcbf_pkg::pcbf_desc_t             desc
);
    import pcbf_pkg::*;

    logic [1:0]        port;
    logic [ADDR_W-1:0] addr;
    logic [6:0]        roff_full;

    // Unpack the transfer and build the queued descriptor.
    always_comb
    begin
        port      = in_data[1:0];
        addr      = in_data[17:2];
        roff_full = 7'({port, 2'b00}) + 7'({port, 1'b0}) + 7'd5;

        desc.is_write     = in_valid & (in_type == REQ_WRITE);
        desc.port         = port;
        desc.addr_word    = (addr & ADDR_KEEP_MASK) | {11'd0, addr_crc5(addr)};
        desc.reply_offset = roff_full[ROFF_W-1:0];
        desc.data         = in_data[DATA_W+17:18];
    end

endmodule

// ===== src/pcbf_queue.sv =====
module pcbf_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pcbf_pkg::pcbf_hs_t   push_hs_in,
    input  pcbf_pkg::pcbf_desc_t push_desc,
    output logic                 push_ready,
    output logic                 pop_valid,
    output pcbf_pkg::pcbf_desc_t pop_desc,
    input  logic                 pop
);
    import pcbf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pcbf_desc_t       mem [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_desc   = mem[rd_ptr_reg];
    assign do_push    = push_hs_in.valid & push_ready;
    assign do_pop     = pop & pop_valid;

    // Pointer and fill-count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== src/pcbf_back.sv =====
module pcbf_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              head_valid,
    input  pcbf_pkg::pcbf_desc_t              head,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pcbf_pkg::OUT_DATA_W-1:0]   out_data,
    output logic                              out_last
);
    import pcbf_pkg::*;

    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        byte_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [ROFF_W-1:0] roff_reg;
    logic              last_reg;
    logic              load;
    logic [7:0]        gen_byte;
    logic [IDX_W-1:0]  base;
    logic [IDX_W-1:0]  rel;
    logic [IDX_W-1:0]  phase;
    logic [4:0]        wr_k;

    // A new byte enters the output register whenever a request is queued and the register is empty or drained.
    assign load = head_valid & (~out_valid_reg | out_ready);
    assign pop  = load & (cnt_reg == LAST_INDEX);

    // Select the byte at the current block position.
    always_comb
    begin
        base  = IDX_W'({head.port, 2'b00}) + IDX_W'({head.port, 1'b0});
        rel   = cnt_reg - base;
        wr_k  = 5'(rel - IDX_W'(5));
        if (cnt_reg < IDX_W'(6))
        begin
            phase = cnt_reg;
        end
        else if (cnt_reg < IDX_W'(12))
        begin
            phase = cnt_reg - IDX_W'(6);
        end
        else
        begin
            phase = cnt_reg - IDX_W'(12);
        end

        gen_byte = BYTE_ZERO;
        if (cnt_reg == LAST_INDEX)
        begin
            gen_byte = BYTE_TAIL;
        end
        else if (cnt_reg < base)
        begin
            case (phase)
                6'd0:    gen_byte = BYTE_PROBE_0;
                6'd1:    gen_byte = BYTE_PROBE_1;
                6'd2:    gen_byte = BYTE_PROBE_2;
                default: gen_byte = BYTE_FILL;
            endcase
        end
        else
        begin
            case (rel)
                6'd0:    gen_byte = head.is_write ? BYTE_WR_0 : BYTE_RD_0;
                6'd1:    gen_byte = head.is_write ? BYTE_WR_1 : BYTE_RD_1;
                6'd2:    gen_byte = head.is_write ? BYTE_WR_2 : BYTE_RD_2;
                6'd3:    gen_byte = head.addr_word[15:8];
                6'd4:    gen_byte = head.addr_word[7:0];
                6'd37:   gen_byte = BYTE_FILL;
                6'd38:   gen_byte = BYTE_END;
                default:
                begin
                    if (rel > IDX_W'(38))
                    begin
                        gen_byte = BYTE_ZERO;
                    end
                    else if (head.is_write)
                    begin
                        gen_byte = head.data[{wr_k, 3'b000} +: 8];
                    end
                    else
                    begin
                        gen_byte = BYTE_FILL;
                    end
                end
            endcase
        end
    end

    // Position counter and output valid.
    always_comb
    begin
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            cnt_next       = cnt_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= gen_byte;
            idx_reg  <= cnt_reg;
            roff_reg <= head.reply_offset;
            last_reg <= (cnt_reg == LAST_INDEX);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {5'd0, roff_reg, idx_reg, byte_reg};
    assign out_last  = last_reg;

endmodule

// ===== src/pak_command_block_framer_core.sv =====
// Channel   Dir  Content
// s_axis    in   tdata: port, address, write_data_0..3; tuser: req_type
// m_axis    out  tdata: block_byte, byte_index, reply_offset; tlast: last
//
// Each request produces 64 output transfers, one per cycle while m_axis
// does not stall; the byte counter in the emitter steps through them.
// Requests wait in a QUEUE_DEPTH-entry queue and are accepted while the
// queue has room, also while a result byte waits to be taken.
// rst_n is asynchronous and active low; it empties the queue and the output.
// A stall on m_axis holds the output register and backs up into the queue.
module pak_command_block_framer_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // port[1:0], address[17:2], write_data_0..3[273:18], zero pad[279:274]
    input  logic [pcbf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // req_type[0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // block_byte[7:0], byte_index[13:8], reply_offset[18:14], zero pad[23:19]
    output logic [pcbf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast
);
    import pcbf_pkg::*;

    pcbf_desc_t in_desc;
    pcbf_desc_t head_desc;
    pcbf_hs_t   push_hs;
    logic       head_valid;
    logic       pop;
    logic       push_ready;

    assign push_hs.valid = s_axis_tvalid;
    assign push_hs.ready = push_ready;
    assign s_axis_tready = push_hs.ready;

    // Classify the request.
    pcbf_front u_front (
        .in_valid (s_axis_tvalid),
        .in_type  (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .desc     (in_desc)
    );

    // Decouple intake from emission.
    pcbf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_hs_in (push_hs),
        .push_desc  (in_desc),
        .push_ready (push_ready),
        .pop_valid  (head_valid),
        .pop_desc   (head_desc),
        .pop        (pop)
    );

    // Emit the block byte by byte.
    pcbf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head_desc),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule
